@@ design/gpm_pkg.sv @@
// Shared constants and types for the glob pattern matcher.
`default_nettype none

package gpm_pkg;

    localparam int PAT_REGS  = 4;
    localparam int PAT_CHARS = 4 * PAT_REGS;
    localparam int LEN_W     = 5;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_LENGTH  = 3'd0;
    localparam reg_idx_t REG_CHARS_0 = 3'd1;
    localparam reg_idx_t REG_CHARS_1 = 3'd2;
    localparam reg_idx_t REG_CHARS_2 = 3'd3;
    localparam reg_idx_t REG_CHARS_3 = 3'd4;

    typedef logic [PAT_REGS-1:0][DATA_W-1:0] pat_regs_t;
    typedef logic [PAT_CHARS-1:0][7:0]       pat_bytes_t;

endpackage : gpm_pkg

`default_nettype wire

@@ design/glob_pattern_matcher_unit.sv @@
// Top level: streaming wildcard glob matcher with APB pattern registers.
//
//  channel   direction  handshake                  payload
//  text      in         text_valid / text_stall    text_char, char_present, last_char
//  result    out        result_valid / result_stall matched
//  config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One item per cycle while no last item is held by a stalled result. Each item
// is held in the input register; the position-set update (star closure, step,
// closure) runs from there into the state and result registers, so a result is
// registered as its last item leaves the input register. State feeds back.
// Reset: pattern registers clear, only position zero active, no item held.
// A held result stalls only an item marked last; other items keep flowing.
`default_nettype none

module glob_pattern_matcher_unit
    import gpm_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              text_valid,
    output logic                   text_stall,
    input  wire logic [7:0]        text_char,
    input  wire logic              char_present,
    input  wire logic              last_char,

    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic                   matched,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int STATE_W = PATTERN_MAX + 1;
    localparam int EFF_MAX = (PATTERN_MAX < PAT_CHARS) ? PATTERN_MAX : PAT_CHARS;

    // configuration
    logic [LEN_W-1:0] length_reg;
    pat_regs_t        chars_reg;
    pat_bytes_t       pat_bytes;
    reg_idx_t         reg_idx;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pat_bytes = chars_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            chars_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_LENGTH:  length_reg   <= pwdata[LEN_W-1:0];
                REG_CHARS_0: chars_reg[0] <= pwdata;
                REG_CHARS_1: chars_reg[1] <= pwdata;
                REG_CHARS_2: chars_reg[2] <= pwdata;
                REG_CHARS_3: chars_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LENGTH:  prdata = {{(DATA_W-LEN_W){1'b0}}, length_reg};
            REG_CHARS_0: prdata = chars_reg[0];
            REG_CHARS_1: prdata = chars_reg[1];
            REG_CHARS_2: prdata = chars_reg[2];
            REG_CHARS_3: prdata = chars_reg[3];
            default:     prdata = '0;
        endcase
    end

    // effective length and per-position pattern masks
    logic [LEN_W-1:0]   eff_len;
    logic [EFF_MAX-1:0] in_use;
    logic [EFF_MAX-1:0] star_pos;
    logic [EFF_MAX-1:0] single_pos;

    assign eff_len = (length_reg > LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX) : length_reg;

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_present_reg;
    logic       s1_last_reg;
    logic       s1_fire;
    logic       out_free;
    logic       text_accept;

    always_comb
    begin
        for (int i = 0; i < EFF_MAX; i++)
        begin
            in_use[i]     = LEN_W'(i) < eff_len;
            star_pos[i]   = in_use[i] && (pat_bytes[i] == STAR_BYTE);
            single_pos[i] = in_use[i] && ((pat_bytes[i] == ANY_BYTE)
                                          || (pat_bytes[i] == s1_char_reg));
        end
    end

    // position set
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] closed_cur;
    logic [STATE_W-1:0] stepped;
    logic [STATE_W-1:0] closed_new;
    logic [STATE_W-1:0] after_item;
    logic               match_now;

    always_comb
    begin
        closed_cur = state_reg;
        for (int i = 0; i < EFF_MAX; i++)
        begin
            if (closed_cur[i] && star_pos[i])
                closed_cur[i+1] = 1'b1;
        end

        stepped = '0;
        for (int i = 0; i < EFF_MAX; i++)
        begin
            if (closed_cur[i] && star_pos[i])
            begin
                stepped[i]   = 1'b1;
                stepped[i+1] = 1'b1;
            end
            else if (closed_cur[i] && single_pos[i])
            begin
                stepped[i+1] = 1'b1;
            end
        end

        closed_new = stepped;
        for (int i = 0; i < EFF_MAX; i++)
        begin
            if (closed_new[i] && star_pos[i])
                closed_new[i+1] = 1'b1;
        end

        after_item = s1_present_reg ? closed_new : closed_cur;

        match_now = 1'b0;
        for (int i = 0; i <= EFF_MAX; i++)
        begin
            if (eff_len == LEN_W'(i))
                match_now = after_item[i];
        end
    end

    // handshake
    logic result_valid_reg;
    logic result_valid_next;
    logic matched_reg;

    assign out_free     = !result_valid_reg || !result_stall;
    assign s1_fire      = s1_valid_reg && (!s1_last_reg || out_free);
    assign text_stall   = s1_valid_reg && !s1_fire;
    assign text_accept  = text_valid && !text_stall;
    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (text_accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (s1_fire && s1_last_reg)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_W'(1);
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_fire)
                state_reg <= s1_last_reg ? STATE_W'(1) : after_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            s1_char_reg    <= text_char;
            s1_present_reg <= char_present;
            s1_last_reg    <= last_char;
        end
        if (s1_fire && s1_last_reg)
            matched_reg <= match_now;
    end

`ifndef ASSERT_OFF
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> state_reg == STATE_W'(1))
        else $error("position set not restarted after last item");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> s1_valid_reg && s1_last_reg)
        else $error("input stalled without a held last item");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_fire && s1_last_reg))
        else $error("result without a finished last item");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg >> (EFF_MAX + 1)) == '0)
        else $error("position beyond pattern capacity active");
`endif

endmodule : glob_pattern_matcher_unit

`default_nettype wire

@@ tb/glob_pattern_matcher_unit_test.sv @@
// Testbench for the glob pattern matcher: streams texts, predicts the match verdicts, checks them.
module glob_pattern_matcher_unit_test;
    import gpm_pkg::*;

    localparam int PAT_MAX     = 16;
    localparam int CLK_HALF    = 6;
    localparam int TEXT_TARGET = 1800;
    localparam int SETTLE      = 4;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MAX_CYCLES  = 400000;

    localparam reg_idx_t REG_SPARE_LO = 3'd5;
    localparam reg_idx_t REG_SPARE_HI = 3'd7;

    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] LETTER_B = 8'h62;
    localparam logic [7:0] LETTER_C = 8'h63;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_BEAT, RX_CHOKE} rx_mode_t;

    class match_scoreboard;
        logic [LEN_W-1:0]  pat_len;
        logic [DATA_W-1:0] pat_word [PAT_REGS];
        logic [PAT_MAX:0]  live;
        bit                match_verdicts[$];
        int                errors;
        int                checked;
        int                hits;

        function void clear();
            pat_len = '0;
            foreach (pat_word[i])
                pat_word[i] = '0;
            live = '0;
            live[0] = 1'b1;
            match_verdicts.delete();
            errors = 0;
            checked = 0;
            hits = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
            if (idx == REG_LENGTH)
                pat_len = v[LEN_W-1:0];
            else if (idx >= REG_CHARS_0 && idx <= REG_CHARS_3)
                pat_word[idx - REG_CHARS_0] = v;
        endfunction

        function int used_len();
            int n;
            n = pat_len;
            if (n > PAT_MAX)
                n = PAT_MAX;
            if (n > PAT_CHARS)
                n = PAT_CHARS;
            return n;
        endfunction

        function logic [7:0] pat_char(int i);
            return pat_word[i / 4][8 * (i % 4) +: 8];
        endfunction

        function void close_stars(int n);
            for (int i = 0; i < n; i++)
                if (live[i] && pat_char(i) == STAR_BYTE)
                    live[i + 1] = 1'b1;
        endfunction

        // advance the active position set by one accepted item
        function void take_item(logic [7:0] c, bit present, bit last);
            int               n;
            logic [PAT_MAX:0] nxt;
            logic [7:0]       p;
            n = used_len();
            close_stars(n);
            if (present)
            begin
                nxt = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (live[i])
                    begin
                        p = pat_char(i);
                        if (p == STAR_BYTE)
                        begin
                            nxt[i] = 1'b1;
                            nxt[i + 1] = 1'b1;
                        end
                        else if (p == ANY_BYTE || p == c)
                            nxt[i + 1] = 1'b1;
                    end
                end
                live = nxt;
                close_stars(n);
            end
            if (last)
            begin
                match_verdicts.insert(match_verdicts.size(), live[n]);
                live = '0;
                live[0] = 1'b1;
            end
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_verdict(bit got);
            bit want;
            if (match_verdicts.size() == 0)
                report("verdict with none pending", 0, got);
            else
            begin
                want = match_verdicts.pop_front();
                checked++;
                hits += got;
                if (want !== got)
                    report("matched", want, got);
            end
        endfunction

        function void check_reg(reg_idx_t idx, logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (idx == REG_LENGTH)
                want = DATA_W'(pat_len);
            else
                want = pat_word[idx - REG_CHARS_0];
            if (got !== want)
                report("register readback", want, got);
        endfunction

        function int pending();
            return match_verdicts.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              text_valid = 1'b0;
    logic              text_stall;
    logic [7:0]        text_char = '0;
    logic              char_present = 1'b0;
    logic              last_char = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              matched;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    match_scoreboard sb;
    rx_mode_t        stall_mode = RX_OPEN;
    int              hold_left = 0;
    int              rx_beat = 0;
    int              burst_left = 0;
    bit              steady = 1'b0;
    int              items_sent = 0;
    int              texts_sent = 0;
    int              settings = 0;
    logic [7:0]      pat_buf[$];
    logic [7:0]      text_buf[$];

    glob_pattern_matcher_unit #(
        .PATTERN_MAX (PAT_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_char    (text_char),
        .char_present (char_present),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // result side: check, then pick next stall value
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_verdict(matched);
        rx_beat++;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                RX_RANDOM: result_stall <= ($urandom_range(0, 9) < 4);
                RX_BEAT:   result_stall <= ((rx_beat % 8) < 5);
                RX_CHOKE:  result_stall <= ($urandom_range(0, 9) < 8);
                default:   result_stall <= 1'b0;
            endcase
        end
    end

    task automatic send_item(logic [7:0] c, bit present, bit last);
        int gap;
        if (!steady && burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        text_valid   <= 1'b1;
        text_char    <= c;
        char_present <= present;
        last_char    <= last;
        do
            @(posedge clk);
        while (text_stall);
        burst_left--;
        sb.take_item(c, present, last);
        if (present || last)
            items_sent++;
    endtask

    task automatic send_text(logic [7:0] txt[$], bit noisy);
        if (txt.size() == 0)
            send_item($urandom_range(0, 255), 1'b0, 1'b1);
        else
        begin
            foreach (txt[i])
            begin
                if (noisy && $urandom_range(0, 4) == 0)
                    send_item($urandom_range(0, 255), 1'b0, 1'b0);
                send_item(txt[i], 1'b1, i == txt.size() - 1);
            end
        end
        texts_sent++;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        text_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic apb_read(reg_idx_t idx, output logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx) << 2;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        v = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_pattern(int n, logic [7:0] pat[$]);
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] got;
        for (int r = 0; r < PAT_REGS; r++)
        begin
            for (int k = 0; k < 4; k++)
                w[8 * k +: 8] = (4 * r + k < pat.size()) ? pat[4 * r + k] : 8'h00;
            apb_write(reg_idx_t'(REG_CHARS_0 + r), w);
        end
        apb_write(REG_LENGTH, DATA_W'(n));
        for (int r = REG_LENGTH; r <= REG_CHARS_3; r++)
        begin
            apb_read(reg_idx_t'(r), got);
            sb.check_reg(reg_idx_t'(r), got);
        end
        settings++;
    endtask

    function automatic logic [7:0] pick_pat_char();
        case ($urandom_range(0, 9))
            0, 1:    return STAR_BYTE;
            2:       return ANY_BYTE;
            9:       return $urandom_range(0, 255);
            default: return LETTER_A + $urandom_range(0, 2);
        endcase
    endfunction

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 11))
            0:       return STAR_BYTE;
            1:       return ANY_BYTE;
            2, 3:    return $urandom_range(0, 255);
            default: return LETTER_A + $urandom_range(0, 2);
        endcase
    endfunction

    // text that follows the pattern, sometimes with one edit
    task automatic build_text(int pat_n);
        int n;
        int pos;
        text_buf.delete();
        n = (pat_n > PAT_CHARS) ? PAT_CHARS : pat_n;
        for (int i = 0; i < n; i++)
        begin
            if (pat_buf[i] == STAR_BYTE)
                repeat ($urandom_range(0, 3))
                    text_buf.insert(text_buf.size(), pick_text_char());
            else if (pat_buf[i] == ANY_BYTE)
                text_buf.insert(text_buf.size(), pick_text_char());
            else
                text_buf.insert(text_buf.size(), pat_buf[i]);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            pos = $urandom_range(0, text_buf.size());
            case ($urandom_range(0, 2))
                0: text_buf.insert(pos, pick_text_char());
                1: if (pos < text_buf.size()) text_buf.delete(pos);
                default: if (pos < text_buf.size()) text_buf[pos] = pick_text_char();
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] pq[$];
        logic [7:0] tq[$];
        int         pat_n;
        int         kind;
        int         phase;
        int         leftover;

        sb = new;
        sb.clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset: only the empty text matches
        tq = {};
        send_text(tq, 1'b0);
        tq = {8'hFF};
        send_text(tq, 1'b0);

        wait_idle();
        pq = {LETTER_A, STAR_BYTE, ANY_BYTE, LETTER_C};
        load_pattern(4, pq);
        // wildcards in the text are plain characters
        tq = {LETTER_A, STAR_BYTE, ANY_BYTE, LETTER_C};
        send_text(tq, 1'b0);
        tq = {LETTER_A, LETTER_C};
        send_text(tq, 1'b0);
        // absent chars inside a text and on the last item
        send_item(LETTER_A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(LETTER_B, 1'b1, 1'b0);
        send_item(LETTER_C, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        texts_sent++;

        // pattern swapped in the middle of a text
        send_item(LETTER_A, 1'b1, 1'b0);
        wait_idle();
        pq = {STAR_BYTE, LETTER_B};
        load_pattern(2, pq);
        send_item(LETTER_B, 1'b1, 1'b1);
        texts_sent++;

        // over-long length clips to the full register set
        wait_idle();
        pq.delete();
        repeat (14) pq.insert(pq.size(), STAR_BYTE);
        pq.insert(pq.size(), 8'hFF);
        pq.insert(pq.size(), 8'h00);
        load_pattern(31, pq);
        tq = {8'hFF, 8'h00};
        send_text(tq, 1'b0);
        tq = {8'h00};
        send_text(tq, 1'b0);
        wait_idle();
        apb_write(REG_SPARE_HI, 32'hFFFF_FFFF);
        load_pattern(16, pq);
        tq = {8'hFF, 8'h00};
        send_text(tq, 1'b0);

        phase = 0;
        while (items_sent < TEXT_TARGET)
        begin
            wait_idle();
            case ($urandom_range(0, 19))
                0:       pat_n = 0;
                1:       pat_n = PAT_CHARS;
                2:       pat_n = $urandom_range(PAT_CHARS + 1, 31);
                default: pat_n = $urandom_range(1, 8);
            endcase
            pat_buf.delete();
            repeat (PAT_CHARS) pat_buf.insert(pat_buf.size(), pick_pat_char());
            if ($urandom_range(0, 3) == 0)
                apb_write(reg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            load_pattern(pat_n, pat_buf);
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            steady = ($urandom_range(0, 4) == 0);
            if (phase == 2)
                hold_left = LONG_HOLD;
            repeat ($urandom_range(10, 30))
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                    build_text(pat_n);
                else
                begin
                    text_buf.delete();
                    repeat ($urandom_range(0, 6))
                        text_buf.insert(text_buf.size(),
                                        kind < 8 ? pick_text_char() : $urandom_range(0, 255));
                end
                send_text(text_buf, kind >= 8 || $urandom_range(0, 9) == 0);
            end
            // leave a text open so the next pattern picks it up
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_item(pick_text_char(), 1'b1, 1'b0);
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge clk);
        leftover = sb.pending();
        if (leftover != 0)
            sb.report("verdicts never delivered", leftover, 0);
        $display("Sent %0d texts (%0d items) over %0d pattern settings.",
                 texts_sent, items_sent, settings);
        $display("Checked %0d verdicts, %0d of them matches.", sb.checked, sb.hits);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #(2 * CLK_HALF * MAX_CYCLES);
        $display("timeout after %0d cycles", MAX_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

endmodule
